>>> design/bmpd_pkg.sv
package bmpd_pkg;

  localparam int unsigned PaletteDepth = 256;
  localparam int unsigned PalAddrW     = 8;
  localparam int unsigned CfgDataW     = 13;

  // register indexes of the configuration port
  localparam logic [1:0] CFG_BPP    = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;
  localparam logic [1:0] CFG_KEEP   = 2'd3;

  // item kinds
  localparam logic REQ_PALETTE = 1'b0;
  localparam logic REQ_PIXEL   = 1'b1;

  // supported depths
  localparam logic [5:0] BPP_1  = 6'd1;
  localparam logic [5:0] BPP_4  = 6'd4;
  localparam logic [5:0] BPP_8  = 6'd8;
  localparam logic [5:0] BPP_16 = 6'd16;
  localparam logic [5:0] BPP_24 = 6'd24;
  localparam logic [5:0] BPP_32 = 6'd32;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  palette_slot;
    logic [31:0] palette_entry;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  pixel_index;
    logic [11:0] column;
    logic [11:0] dest_row;
    logic        last_of_run;
    logic        end_of_image;
    logic        has_color;
    logic        has_alpha;
    logic        bad_depth;
  } out_item_t;

  // one pixel handed from the unpacker to the color stage
  typedef struct packed {
    logic        use_pal;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  pixel_index;
    logic [11:0] column;
    logic [11:0] dest_row;
    logic        last_of_run;
    logic        end_of_image;
    logic        clr_flags;
    logic        clr_value;
    logic        alpha_hit;
    logic        bad_depth;
  } pix_t;

endpackage

>>> design/bmpd_palette_ram.sv
module bmpd_palette_ram import bmpd_pkg::*; (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [PalAddrW-1:0] waddr_i,
  input  logic [31:0]         wdata_i,
  input  logic                re_i,
  input  logic [PalAddrW-1:0] raddr_i,
  output logic [31:0]         rdata_o
);

  logic [31:0] mem [PaletteDepth];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/bmpd_pixel_out.sv
module bmpd_pixel_out import bmpd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      keep_index_i,
  input  logic      pix_valid_i,
  output logic      pix_ready_o,
  input  pix_t      pix_i,
  input  logic [31:0] pal_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic      b_valid_q;
  pix_t      b_q;
  logic      color_q, color_d;
  logic      alpha_q, alpha_d;
  logic      o_valid_q;
  out_item_t o_q, o_d;
  logic      b_move;
  logic [7:0] r, g, b, a;

  assign b_move      = b_valid_q && (!o_valid_q || out_ready_i);
  assign pix_ready_o = !b_valid_q || b_move;

  always_comb begin
    if (b_q.use_pal) begin
      r = pal_data_i[23:16];
      g = pal_data_i[15:8];
      b = pal_data_i[7:0];
      a = pal_data_i[31:24];
    end else begin
      r = b_q.red;
      g = b_q.green;
      b = b_q.blue;
      a = b_q.alpha;
    end
    color_d = b_q.clr_flags ? b_q.clr_value : color_q;
    alpha_d = b_q.clr_flags ? 1'b0 : alpha_q;
    if (!keep_index_i && (r != g || g != b)) begin
      color_d = 1'b1;
    end
    if (b_q.alpha_hit) begin
      alpha_d = 1'b1;
    end
    o_d              = '0;
    o_d.red          = r;
    o_d.green        = g;
    o_d.blue         = b;
    o_d.alpha        = a;
    o_d.pixel_index  = b_q.pixel_index;
    o_d.column       = b_q.column;
    o_d.dest_row     = b_q.dest_row;
    o_d.last_of_run  = b_q.last_of_run;
    o_d.end_of_image = b_q.end_of_image;
    o_d.has_color    = color_d;
    o_d.has_alpha    = alpha_d;
    if (b_q.bad_depth) begin
      o_d           = '0;
      o_d.bad_depth = 1'b1;
      color_d       = color_q;
      alpha_d       = alpha_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
      color_q   <= 1'b0;
      alpha_q   <= 1'b0;
    end else begin
      if (pix_ready_o) begin
        b_valid_q <= pix_valid_i;
      end
      if (b_move) begin
        o_valid_q <= 1'b1;
        color_q   <= color_d;
        alpha_q   <= alpha_d;
      end else if (out_ready_i) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_ready_o && pix_valid_i) begin
      b_q <= pix_i;
    end
    if (b_move) begin
      o_q <= o_d;
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_item_o  = o_q;

endmodule

>>> design/bmp_pixel_decoder.sv
// Uncompressed BMP pixel decoder. Palette writes and pixel data bytes share one
// input channel and are handled strictly in order; results come out as RGBA
// pixels with column and bottom-up row. Palette writes, padding bytes and
// 8/16/24/32bpp bytes go at one item per cycle while the output does not stall;
// a 4bpp byte yields up to two pixels and a 1bpp byte up to eight, since the
// unpacker emits one pixel per unstalled cycle into the single palette read port.
// The palette RAM is not cleared: reading a slot never written gives garbage.
// Configuration may only be written while the block is idle.
module bmp_pixel_decoder import bmpd_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_item_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);

  // configuration
  logic [5:0]          cfg_bpp_q;
  logic [CfgDataW-1:0] cfg_width_q;
  logic [CfgDataW-1:0] cfg_height_q;
  logic                cfg_keep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_bpp_q    <= BPP_24;
      cfg_width_q  <= CfgDataW'(1);
      cfg_height_q <= CfgDataW'(1);
      cfg_keep_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BPP:    cfg_bpp_q    <= cfg_wdata_i[5:0];
        CFG_WIDTH:  cfg_width_q  <= cfg_wdata_i;
        CFG_HEIGHT: cfg_height_q <= cfg_wdata_i;
        CFG_KEEP:   cfg_keep_q   <= cfg_wdata_i[0];
        default:    ;
      endcase
    end
  end

  // effective image size
  logic [31:0] w32, h32;
  logic [CW:0] w_eff;
  logic [RW:0] h_eff;

  always_comb begin
    w32 = 32'(cfg_width_q);
    h32 = 32'(cfg_height_q);
    if (w32 == 32'd0) w32 = 32'd1;
    if (w32 > MAX_WIDTH) w32 = MAX_WIDTH;
    if (h32 == 32'd0) h32 = 32'd1;
    if (h32 > MAX_HEIGHT) h32 = MAX_HEIGHT;
  end

  assign w_eff = w32[CW:0];
  assign h_eff = h32[RW:0];

  // row padding only depends on the row bit count modulo 32
  logic [9:0] bits_prod;
  logic [5:0] nbytes_sum;
  logic [1:0] pad_row;

  assign bits_prod  = w32[4:0] * cfg_bpp_q[4:0];
  assign nbytes_sum = {1'b0, bits_prod[4:0]} + 6'd7;
  assign pad_row    = 2'd0 - nbytes_sum[4:3];

  // depth decode
  logic is1, is4, is8, is16, is24, is32, bad, wide;
  logic [2:0] need;

  assign is1  = cfg_bpp_q == BPP_1;
  assign is4  = cfg_bpp_q == BPP_4;
  assign is8  = cfg_bpp_q == BPP_8;
  assign is16 = cfg_bpp_q == BPP_16;
  assign is24 = cfg_bpp_q == BPP_24;
  assign is32 = cfg_bpp_q == BPP_32;
  assign bad  = !(is1 || is4 || is8 || is16 || is24 || is32);
  assign wide = is16 || is24 || is32;
  assign need = is16 ? 3'd2 : (is24 ? 3'd3 : 3'd4);

  // unpacker stage: holds one item and walks its pixels
  logic          a_valid_q;
  in_item_t      a_item_q;
  logic [2:0]    a_sub_q;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [1:0]    phase_q, phase_d;
  logic [23:0]   part_q, part_d;
  logic [1:0]    pad_q, pad_d;
  logic          clr_pend_q, clr_pend_d;
  logic          clr_val_q, clr_val_d;

  logic          is_wr, is_px, first, pad_path, part_path, emit, last, done, fire;
  logic          start, start_val, row_end, pix_ready;
  logic [CW-1:0] col_eff;
  logic [RW-1:0] row_eff;
  logic [CW:0]   col_inc;
  logic [RW:0]   row_inc, row_raw_inc;
  logic [31:0]   col32, dr32, part32;
  logic [15:0]   sp;
  logic [3:0]    nib;
  logic          bit_v;
  logic [7:0]    pal_addr;
  pix_t          pix;
  logic [31:0]   pal_data;

  assign is_wr     = a_valid_q && (a_item_q.req_type == REQ_PALETTE);
  assign is_px     = a_valid_q && (a_item_q.req_type == REQ_PIXEL);
  assign first     = a_sub_q == 3'd0;
  assign pad_path  = is_px && !bad && first && (pad_q != 2'd0);
  assign part_path = is_px && !bad && !pad_path && wide && ({1'b0, phase_q} + 3'd1 < need);
  assign emit      = is_px && !pad_path && !part_path;
  assign start     = is_px && !bad && !pad_path && first &&
                     col_q == '0 && row_q == '0 && phase_q == 2'd0;
  assign start_val = cfg_keep_q && is8;

  assign col_eff     = ({1'b0, col_q} >= w_eff) ? '0 : col_q;
  assign row_eff     = ({1'b0, row_q} >= h_eff) ? '0 : row_q;
  assign col_inc     = {1'b0, col_eff} + (CW + 1)'(1);
  assign row_inc     = {1'b0, row_eff} + (RW + 1)'(1);
  assign row_raw_inc = {1'b0, row_q} + (RW + 1)'(1);
  assign row_end     = col_inc >= w_eff;
  assign col32       = 32'(col_eff);
  assign dr32        = 32'(h_eff) - 32'(row_eff) - 32'd1;
  assign sp          = {a_item_q.data_byte, part_q[7:0]};
  assign nib         = first ? a_item_q.data_byte[7:4] : a_item_q.data_byte[3:0];
  assign bit_v       = a_item_q.data_byte[3'd7 - a_sub_q];
  assign part32      = {8'd0, part_q} | (32'(a_item_q.data_byte) << {phase_q, 3'b000});

  always_comb begin
    pix      = '0;
    last     = 1'b1;
    pal_addr = a_item_q.data_byte;
    if (is1) begin
      pix.red         = {8{bit_v}};
      pix.green       = {8{bit_v}};
      pix.blue        = {8{bit_v}};
      pix.pixel_index = {7'd0, bit_v};
      last            = (a_sub_q == 3'd7) || row_end;
    end else if (is4) begin
      pix.use_pal     = 1'b1;
      pix.pixel_index = {4'd0, nib};
      pal_addr        = {4'd0, nib};
      last            = !first || row_end;
    end else if (is8) begin
      pix.use_pal     = 1'b1;
      pix.pixel_index = a_item_q.data_byte;
    end else if (is16) begin
      pix.red   = {sp[14:10], 3'd0};
      pix.green = {sp[9:5], 3'd0};
      pix.blue  = {sp[4:0], 3'd0};
      pix.alpha = 8'hFF;
    end else if (is24) begin
      pix.red   = a_item_q.data_byte;
      pix.green = part_q[15:8];
      pix.blue  = part_q[7:0];
      pix.alpha = 8'hFF;
    end else begin
      pix.red       = part_q[23:16];
      pix.green     = part_q[15:8];
      pix.blue      = part_q[7:0];
      pix.alpha     = a_item_q.data_byte;
      pix.alpha_hit = a_item_q.data_byte != 8'hFF;
    end
    pix.column       = col32[11:0];
    pix.dest_row     = dr32[11:0];
    pix.last_of_run  = last;
    pix.end_of_image = row_end && (row_inc >= h_eff);
    pix.clr_flags    = clr_pend_q || start;
    pix.clr_value    = start ? start_val : clr_val_q;
    if (bad) begin
      pix           = '0;
      pix.bad_depth = 1'b1;
      last          = 1'b1;
    end
  end

  assign fire       = a_valid_q && (!emit || pix_ready);
  assign done       = is_wr || pad_path || part_path || (emit && last);
  assign in_ready_o = !a_valid_q || (fire && done);

  always_comb begin
    col_d      = col_q;
    row_d      = row_q;
    phase_d    = phase_q;
    part_d     = part_q;
    pad_d      = pad_q;
    clr_pend_d = clr_pend_q;
    clr_val_d  = clr_val_q;
    if (fire && is_px && !bad) begin
      if (pad_path) begin
        pad_d = pad_q - 2'd1;
        if (pad_q == 2'd1) begin
          row_d = (row_raw_inc >= h_eff) ? '0 : row_raw_inc[RW-1:0];
        end
      end else if (part_path) begin
        part_d  = part32[23:0];
        phase_d = phase_q + 2'd1;
        if (start) begin
          // flags clear with the first pixel that reaches the color stage
          clr_pend_d = 1'b1;
          clr_val_d  = start_val;
        end
      end else begin
        clr_pend_d = 1'b0;
        row_d      = row_eff;
        if (row_end) begin
          col_d = '0;
          if (pad_row != 2'd0) begin
            pad_d = pad_row;
          end else begin
            row_d = (row_inc >= h_eff) ? '0 : row_inc[RW-1:0];
          end
        end else begin
          col_d = col_inc[CW-1:0];
        end
        if (wide) begin
          phase_d = 2'd0;
          part_d  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q  <= 1'b0;
      a_sub_q    <= 3'd0;
      col_q      <= '0;
      row_q      <= '0;
      phase_q    <= 2'd0;
      part_q     <= '0;
      pad_q      <= 2'd0;
      clr_pend_q <= 1'b0;
      clr_val_q  <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      phase_q    <= phase_d;
      part_q     <= part_d;
      pad_q      <= pad_d;
      clr_pend_q <= clr_pend_d;
      clr_val_q  <= clr_val_d;
      if (in_ready_o) begin
        a_valid_q <= in_valid_i;
        a_sub_q   <= 3'd0;
      end else if (fire) begin
        a_sub_q <= a_sub_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      a_item_q <= in_item_i;
    end
  end

  bmpd_palette_ram u_palette (
    .clk_i   (clk_i),
    .we_i    (is_wr),
    .waddr_i (a_item_q.palette_slot),
    .wdata_i (a_item_q.palette_entry),
    .re_i    (emit && pix_ready),
    .raddr_i (pal_addr),
    .rdata_o (pal_data)
  );

  bmpd_pixel_out u_pixel_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .keep_index_i (cfg_keep_q),
    .pix_valid_i  (emit),
    .pix_ready_o  (pix_ready),
    .pix_i        (pix),
    .pal_data_i   (pal_data),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_o   (out_item_o)
  );

endmodule
